// ----- hdl/mcck_pkg.sv -----
// Shared types and constants for the minimum-cost cover knapsack table.
`default_nettype none

package mcck_pkg;

  localparam int UNITS_W    = 16;
  localparam int PRICE_W    = 30;
  localparam int INDEX_W    = 12;
  localparam int TARGET_W   = 12;
  localparam int OUT_COST_W = 40;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd4095;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [UNITS_W-1:0]   units;
    logic [PRICE_W-1:0]   price;
    logic [INDEX_W-1:0]   index;
  } in_word_t;

  typedef struct packed {
    logic [OUT_COST_W-1:0] cost;
    logic                  reachable;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_WALK  = 3'd2,
    ST_DRAIN = 3'd3,
    ST_READ  = 3'd4
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/mcck_ram.sv -----
// Cost table memory: one write port, two registered read ports.
`default_nettype none

module mcck_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 41
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic      [DATA_W-1:0]        rd_a_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic      [DATA_W-1:0]        rd_b_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/mcck_relax.sv -----
// Relaxation of one table entry against a shifted entry plus the offer price.
`default_nettype none

module mcck_relax #(
  parameter int COST_BITS = 40
) (
  input  wire logic [COST_BITS:0]             old_entry,
  input  wire logic [COST_BITS:0]             src_entry,
  input  wire logic [mcck_pkg::PRICE_W-1:0]   price,
  output logic                                upd,
  output logic      [COST_BITS:0]             new_entry
);

  localparam int SUM_W = ((COST_BITS > mcck_pkg::PRICE_W) ? COST_BITS : mcck_pkg::PRICE_W) + 1;
  localparam logic [SUM_W-1:0] COST_MAX_EXT = SUM_W'({COST_BITS{1'b1}});

  logic [SUM_W-1:0]     sum;
  logic [COST_BITS-1:0] cand;

  always_comb begin
    sum  = SUM_W'(src_entry[COST_BITS-1:0]) + SUM_W'(price);
    cand = (sum > COST_MAX_EXT) ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];
    upd  = src_entry[COST_BITS] &&
           (!old_entry[COST_BITS] || (cand < old_entry[COST_BITS-1:0]));
    new_entry = {1'b1, cand};
  end

endmodule

`default_nettype wire

// ----- hdl/min_cost_cover_knapsack_dp.sv -----
// Min-cost cover knapsack table: control, walk pipeline and result register.
// Sequencing: an accepted read passes through ST_READ, which registers its result word; the
// next word is taken back in ST_IDLE, after the ST_CLEAR pass for a clear, and for an add with
// top = min(running total, target) nonzero after ST_WALK, one entry per cycle from top down
// to 1, then ST_DRAIN. Reset: synchronous, active low; then a clearing pass over every entry
// runs before the first word is accepted (configuration writes are taken throughout).
`default_nettype none

module min_cost_cover_knapsack_dp #(
  parameter int TABLE_DEPTH = 4096,
  parameter int COST_BITS   = 40
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire mcck_pkg::in_word_t           in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output mcck_pkg::out_word_t               out_data,
  input  wire logic                         cfg_wr_en,
  input  wire logic [mcck_pkg::TARGET_W-1:0] cfg_wr_data
);

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int ENTRY_W = COST_BITS + 1;
  localparam int SRC_W   = (ADDR_W > mcck_pkg::UNITS_W) ? ADDR_W : mcck_pkg::UNITS_W;
  localparam int SUM_W   = SRC_W + 1;
  localparam int CMP_W   = (ADDR_W > mcck_pkg::TARGET_W) ? ADDR_W : mcck_pkg::TARGET_W;
  localparam int IDX_W   = (ADDR_W > mcck_pkg::INDEX_W) ? ADDR_W : mcck_pkg::INDEX_W;
  localparam logic [SUM_W-1:0]  LAST_SUM  = SUM_W'(TABLE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]    DEPTH_IDX = (IDX_W + 1)'(TABLE_DEPTH);

  mcck_pkg::state_t state_r, state_nxt;

  logic [mcck_pkg::TARGET_W-1:0] target_r;
  logic [ADDR_W-1:0]             running_r, running_nxt;
  logic [ADDR_W-1:0]             clr_r, clr_nxt;
  logic [ADDR_W-1:0]             j_r, j_nxt;
  logic [mcck_pkg::UNITS_W-1:0]  units_r, units_nxt;
  logic [mcck_pkg::PRICE_W-1:0]  price_r, price_nxt;
  logic                          pipe_v_r, pipe_v_nxt;
  logic [ADDR_W-1:0]             pipe_j_r, pipe_j_nxt;
  logic                          idx_ok_r, idx_ok_nxt;
  logic                          out_valid_r, out_valid_nxt;
  mcck_pkg::out_word_t           out_r, out_nxt;

  logic                  accept;
  logic [SUM_W-1:0]      run_sum;
  logic [SUM_W-1:0]      run_sat;
  logic [ADDR_W-1:0]     run_new;
  logic [CMP_W-1:0]      run_cmp;
  logic [CMP_W-1:0]      tgt_cmp;
  logic [CMP_W-1:0]      top_cmp;
  logic [IDX_W-1:0]      idx_ext;
  logic [SRC_W-1:0]      j_ext;
  logic [SRC_W-1:0]      u_ext;
  logic [SRC_W-1:0]      src_full;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]    wr_data;
  logic [ADDR_W-1:0]     rd_a_addr;
  logic [ADDR_W-1:0]     rd_b_addr;
  logic [ENTRY_W-1:0]    rd_a_data;
  logic [ENTRY_W-1:0]    rd_b_data;
  logic                  relax_upd;
  logic [ENTRY_W-1:0]    relax_entry;
  logic [63:0]           rd_cost_ext;

  mcck_ram #(
    .DEPTH  (TABLE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  mcck_relax #(
    .COST_BITS (COST_BITS)
  ) u_relax (
    .old_entry (rd_a_data),
    .src_entry (rd_b_data),
    .price     (price_r),
    .upd       (relax_upd),
    .new_entry (relax_entry)
  );

  // handshake and shared arithmetic
  always_comb begin
    in_ready = (state_r == mcck_pkg::ST_IDLE) &&
               ((in_data.kind != mcck_pkg::KIND_READ) || !out_valid_r || out_ready);
    accept   = in_valid && in_ready;

    run_sum  = SUM_W'(running_r) + SUM_W'(in_data.units);
    run_sat  = (run_sum > LAST_SUM) ? LAST_SUM : run_sum;
    run_new  = run_sat[ADDR_W-1:0];
    run_cmp  = CMP_W'(run_new);
    tgt_cmp  = CMP_W'(target_r);
    top_cmp  = (run_cmp < tgt_cmp) ? run_cmp : tgt_cmp;

    idx_ext  = IDX_W'(in_data.index);

    j_ext    = SRC_W'(j_r);
    u_ext    = SRC_W'(units_r);
    src_full = (j_ext > u_ext) ? (j_ext - u_ext) : '0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcck_pkg::ST_CLEAR: begin
        if (clr_r == LAST_ADDR) begin
          state_nxt = mcck_pkg::ST_IDLE;
        end
      end
      mcck_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            mcck_pkg::KIND_CLEAR: state_nxt = mcck_pkg::ST_CLEAR;
            mcck_pkg::KIND_ADD: begin
              if (top_cmp != '0) begin
                state_nxt = mcck_pkg::ST_WALK;
              end
            end
            mcck_pkg::KIND_READ: state_nxt = mcck_pkg::ST_READ;
            default:             state_nxt = mcck_pkg::ST_IDLE;
          endcase
        end
      end
      mcck_pkg::ST_WALK: begin
        if (j_r == ADDR_W'(1)) begin
          state_nxt = mcck_pkg::ST_DRAIN;
        end
      end
      mcck_pkg::ST_DRAIN: state_nxt = mcck_pkg::ST_IDLE;
      mcck_pkg::ST_READ:  state_nxt = mcck_pkg::ST_IDLE;
      default:            state_nxt = mcck_pkg::ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    running_nxt   = running_r;
    clr_nxt       = clr_r;
    j_nxt         = j_r;
    units_nxt     = units_r;
    price_nxt     = price_r;
    pipe_v_nxt    = 1'b0;
    pipe_j_nxt    = j_r;
    idx_ok_nxt    = idx_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    rd_a_addr     = j_r;
    rd_b_addr     = src_full[ADDR_W-1:0];
    rd_cost_ext   = 64'(rd_a_data[COST_BITS-1:0]);
    wr_en         = pipe_v_r && relax_upd;
    wr_addr       = pipe_j_r;
    wr_data       = relax_entry;

    case (state_r)
      mcck_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = {(clr_r == '0), {COST_BITS{1'b0}}};
        clr_nxt = clr_r + ADDR_W'(1);
      end
      mcck_pkg::ST_IDLE: begin
        rd_a_addr = idx_ext[ADDR_W-1:0];
        if (accept) begin
          case (in_data.kind)
            mcck_pkg::KIND_CLEAR: begin
              running_nxt = '0;
              clr_nxt     = '0;
            end
            mcck_pkg::KIND_ADD: begin
              running_nxt = run_new;
              j_nxt       = top_cmp[ADDR_W-1:0];
              units_nxt   = in_data.units;
              price_nxt   = in_data.price;
            end
            mcck_pkg::KIND_READ: begin
              idx_ok_nxt = ({1'b0, idx_ext} < DEPTH_IDX);
            end
            default: begin
              running_nxt = running_r;
            end
          endcase
        end
      end
      mcck_pkg::ST_WALK: begin
        pipe_v_nxt = 1'b1;
        pipe_j_nxt = j_r;
        j_nxt      = j_r - ADDR_W'(1);
      end
      mcck_pkg::ST_DRAIN: begin
        pipe_v_nxt = 1'b0;
      end
      mcck_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        if (rd_a_data[COST_BITS] && idx_ok_r) begin
          out_nxt.cost      = rd_cost_ext[mcck_pkg::OUT_COST_W-1:0];
          out_nxt.reachable = 1'b1;
        end else begin
          out_nxt.cost      = '0;
          out_nxt.reachable = 1'b0;
        end
      end
      default: begin
        pipe_v_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcck_pkg::ST_CLEAR;
      target_r    <= mcck_pkg::TARGET_RESET;
      running_r   <= '0;
      clr_r       <= '0;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      clr_r       <= clr_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    units_r  <= units_nxt;
    price_r  <= price_nxt;
    pipe_j_r <= pipe_j_nxt;
    idx_ok_r <= idx_ok_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // write-back trails the read pointer by exactly one entry during a walk
  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcck_pkg::ST_WALK && pipe_v_r) |-> (pipe_j_r == j_r + ADDR_W'(1)))
    else $error("walk write-back out of step with read pointer");

  // source entry never lies above the entry being relaxed
  a_src_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcck_pkg::ST_WALK) |-> (rd_b_addr <= j_r))
    else $error("walk source above target entry");

  // table untouched while idle or reading
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcck_pkg::ST_IDLE || state_r == mcck_pkg::ST_READ) |-> !wr_en)
    else $error("table written outside clear or walk");

  // a result word only appears after a read lookup
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == mcck_pkg::ST_READ))
    else $error("result word without read lookup");
`endif

endmodule

`default_nettype wire
